// File: hw/rtl/dia_pkg.sv
// dia_pkg: shared types and constants for the dedup id allocator.
// No dependencies.
package dia_pkg;
    localparam int TypeEntries  = 64;
    localparam int ConstEntries = 64;
    localparam int TIdxW = $clog2(TypeEntries + 1);
    localparam int CIdxW = $clog2(ConstEntries + 1);
    localparam int IdxW  = (TIdxW > CIdxW) ? TIdxW : CIdxW;
    localparam int TAddrW = (TypeEntries > 1) ? $clog2(TypeEntries) : 1;
    localparam int CAddrW = (ConstEntries > 1) ? $clog2(ConstEntries) : 1;
    localparam int KeySlots = 7;
    localparam int WordShift = 16;
    localparam logic [15:0] OP_CONST_TRUE  = 16'd41;
    localparam logic [15:0] OP_CONST_FALSE = 16'd42;
    localparam logic [15:0] OP_CONST       = 16'd43;
    // type key: opcode + 7 operands; const key: opcode, tid, value, wide
    localparam int TKeyW = 16 + 32 * KeySlots;
    localparam int CKeyW = 16 + 32 + 64 + 1;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_ADDED = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // classified request handed from front to back
    typedef struct packed {
        logic                func;
        logic [TKeyW-1:0]    tkey;
        logic [CKeyW-1:0]    ckey;
        logic [3:0]          nwords;
        logic [8:0][31:0]    words; // word 1 or 2 (per id_slot) filled with id later
        logic                id_slot; // 0: id in word1, 1: id in word2
    } req_t;

    typedef enum logic [2:0] {
        B_IDLE, B_READ, B_CMP, B_EMIT
    } bstate_t;
endpackage

// File: hw/rtl/dia_ram.sv
// dia_ram: generic single-port RAM with registered read.
// No dependencies.
module dia_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
    input  logic [Width-1:0]                        wdata,
    output logic [Width-1:0]                        rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: hw/rtl/dia_front.sv
// dia_front: accepts requests, builds keys and word images, feeds a 2-deep queue.
// Depends on dia_pkg.
module dia_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             func,
    input  logic [15:0]      opcode,
    input  logic [2:0]       num_operands,
    input  logic [31:0]      operand_a,
    input  logic [31:0]      operand_b,
    input  logic [31:0]      operand_c,
    input  logic [31:0]      operand_d,
    input  logic [31:0]      operand_e,
    input  logic [31:0]      operand_f,
    input  logic [31:0]      operand_g,
    input  logic             is_wide,
    input  logic             is_boolean,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             q_valid,
    output dia_pkg::req_t    q_req,
    input  logic             q_pop
);
    import dia_pkg::*;

    logic [6:0][31:0] ops;
    logic [6:0][31:0] slot;
    req_t             req;
    logic [15:0]      cop;
    logic [63:0]      val;
    req_t             q_reg [2];
    logic             rd_reg, wr_reg;
    logic [1:0]       cnt_reg;

    assign ops = {operand_g, operand_f, operand_e, operand_d,
                  operand_c, operand_b, operand_a};

    always_comb
    begin
        for (int j = 0; j < KeySlots; j++)
        begin
            slot[j] = (3'(j) < num_operands) ? ops[j] : 32'd0;
        end
        cop = is_boolean ? (({operand_c, operand_b} != 64'd0) ? OP_CONST_TRUE
                                                              : OP_CONST_FALSE)
                         : OP_CONST;
        val = is_wide ? {operand_c, operand_b} : {32'd0, operand_b};
        req = '0;
        req.func = func;
        req.tkey = {slot, opcode};
        req.ckey = {is_wide, val, operand_a, cop};
        if (!func)
        begin
            req.nwords   = 4'(num_operands) + 4'd2;
            req.words[0] = {12'd0, 4'(num_operands) + 4'd2, opcode};
            for (int j = 0; j < KeySlots; j++)
            begin
                req.words[j + 2] = slot[j];
            end
            req.id_slot = 1'b0;
        end
        else
        begin
            req.nwords   = is_boolean ? 4'd3 : (is_wide ? 4'd5 : 4'd4);
            req.words[0] = {12'd0, req.nwords, cop};
            req.words[1] = operand_a;
            req.words[3] = operand_b;
            req.words[4] = operand_c;
            req.id_slot  = 1'b1;
        end
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            q_reg[wr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(in_valid && !in_stall) - 2'(q_pop);
        end
    end
endmodule

// File: hw/rtl/dia_back.sv
// dia_back: scans key RAMs, allocates ids, streams result items.
// Depends on dia_pkg, dia_ram.
module dia_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  dia_pkg::req_t    q_req,
    output logic             q_pop,
    output logic [31:0]      result_id,
    output logic [1:0]       status,
    output logic [31:0]      word,
    output logic             word_valid,
    output logic             last_word,
    output logic             out_valid,
    input  logic             out_stall
);
    import dia_pkg::*;

    bstate_t         state_reg, state_next;
    logic [31:0]     nid_reg, nid_next;
    logic [TIdxW-1:0] tfill_reg, tfill_next;
    logic [CIdxW-1:0] cfill_reg, cfill_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic [3:0]      k_reg, k_next;
    logic [31:0]     id_reg, id_next;
    status_t         st_reg, st_next;
    logic            ov_reg, ov_next;
    logic            tfull, cfull, at_end;
    logic            twe, cwe;
    logic [TAddrW-1:0] taddr;
    logic [CAddrW-1:0] caddr;
    logic [TKeyW+31:0] trd;
    logic [CKeyW+31:0] crd;
    logic [31:0]     wsel;

    assign tfull = (tfill_reg == TIdxW'(TypeEntries));
    assign cfull = (cfill_reg == CIdxW'(ConstEntries));
    assign at_end = q_req.func ? (idx_reg == IdxW'(cfill_reg))
                               : (idx_reg == IdxW'(tfill_reg));

    dia_ram #(.Width(TKeyW + 32), .Depth(TypeEntries)) u_tram (
        .clk(clk), .we(twe), .addr(taddr),
        .wdata({nid_reg, q_req.tkey}), .rdata(trd));
    dia_ram #(.Width(CKeyW + 32), .Depth(ConstEntries)) u_cram (
        .clk(clk), .we(cwe), .addr(caddr),
        .wdata({nid_reg, q_req.ckey}), .rdata(crd));

    always_comb
    begin
        wsel = q_req.words[k_reg];
        if ((k_reg == 4'd1 && !q_req.id_slot) || (k_reg == 4'd2 && q_req.id_slot))
        begin
            wsel = id_reg;
        end
    end

    assign out_valid  = ov_reg;
    assign result_id  = id_reg;
    assign status     = st_reg;
    assign word       = (st_reg == ST_ADDED) ? wsel : 32'd0;
    assign word_valid = (st_reg == ST_ADDED);
    assign last_word  = (st_reg != ST_ADDED) || (k_reg == q_req.nwords - 4'd1);

    always_comb
    begin
        state_next = state_reg;
        nid_next = nid_reg; tfill_next = tfill_reg; cfill_next = cfill_reg;
        idx_next = idx_reg; k_next = k_reg; id_next = id_reg;
        st_next = st_reg; ov_next = ov_reg;
        twe = 1'b0; cwe = 1'b0; q_pop = 1'b0;
        taddr = TAddrW'(idx_reg);
        caddr = CAddrW'(idx_reg);
        unique case (state_reg)
            B_IDLE:
            begin
                idx_next = '0;
                if (q_valid)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                if (at_end)
                begin
                    ov_next = 1'b1;
                    k_next = '0;
                    state_next = B_EMIT;
                    if (q_req.func ? cfull : tfull)
                    begin
                        id_next = '0; st_next = ST_FULL;
                    end
                    else
                    begin
                        id_next = nid_reg; st_next = ST_ADDED;
                        nid_next = nid_reg + 32'd1;
                        if (q_req.func)
                        begin
                            cwe = 1'b1; caddr = CAddrW'(cfill_reg);
                            cfill_next = cfill_reg + CIdxW'(1);
                        end
                        else
                        begin
                            twe = 1'b1; taddr = TAddrW'(tfill_reg);
                            tfill_next = tfill_reg + TIdxW'(1);
                        end
                    end
                end
                else
                begin
                    state_next = B_CMP;
                end
            end
            B_CMP:
            begin
                if (q_req.func ? (crd[CKeyW-1:0] == q_req.ckey)
                               : (trd[TKeyW-1:0] == q_req.tkey))
                begin
                    id_next = q_req.func ? crd[CKeyW+:32] : trd[TKeyW+:32];
                    st_next = ST_FOUND; ov_next = 1'b1; k_next = '0;
                    state_next = B_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + IdxW'(1);
                    state_next = B_READ;
                end
            end
            B_EMIT:
            begin
                if (!out_stall)
                begin
                    if (last_word)
                    begin
                        ov_next = 1'b0; q_pop = 1'b1; state_next = B_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE; nid_reg <= 32'd1;
            tfill_reg <= '0; cfill_reg <= '0; ov_reg <= 1'b0;
            idx_reg <= '0; k_reg <= '0; id_reg <= '0; st_reg <= ST_FOUND;
        end
        else
        begin
            state_reg <= state_next; nid_reg <= nid_next;
            tfill_reg <= tfill_next; cfill_reg <= cfill_next; ov_reg <= ov_next;
            idx_reg <= idx_next; k_reg <= k_next; id_reg <= id_next;
            st_reg <= st_next;
        end
    end
endmodule

// File: hw/rtl/dedup_id_allocator.sv
// dedup_id_allocator: top level; front classifier, request queue, back engine.
// Depends on dia_pkg, dia_front, dia_back, dia_ram.
//
// Hash-consing table for type and constant requests. Each request is keyed
// and compared against stored keys one entry at a time (RAM read in B_READ,
// then compare in B_CMP); the result is then streamed as one item for
// found/full or up to 9 words for a new entry. The search loop over the key
// RAM is the slow part, growing with the table fill. A two-entry queue lets
// the next request be accepted while the back end works. The id counter
// starts at 1 and is shared by both tables.
module dedup_id_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [15:0] opcode,
    input  logic [2:0]  num_operands,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic [31:0] operand_c,
    input  logic [31:0] operand_d,
    input  logic [31:0] operand_e,
    input  logic [31:0] operand_f,
    input  logic [31:0] operand_g,
    input  logic        is_wide,
    input  logic        is_boolean,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_id,
    output logic [1:0]  status,
    output logic [31:0] word,
    output logic        word_valid,
    output logic        last_word
);
    import dia_pkg::*;

    logic q_valid, q_pop;
    req_t q_req;

    dia_front u_front (
        .clk, .rst_n, .func, .opcode, .num_operands, .operand_a, .operand_b,
        .operand_c, .operand_d, .operand_e, .operand_f, .operand_g, .is_wide,
        .is_boolean, .in_valid, .in_stall, .q_valid, .q_req, .q_pop);

    dia_back u_back (
        .clk, .rst_n, .q_valid, .q_req, .q_pop, .result_id, .status, .word,
        .word_valid, .last_word, .out_valid, .out_stall);
endmodule

// File: hw/rtl/dia_checker.sv
// dia_checker: port-level assertions for dedup_id_allocator, plus bind.
// Depends on dia_pkg and the dedup_id_allocator ports.
module dia_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_id,
    input logic [1:0]  status,
    input logic        word_valid,
    input logic        last_word
);
    import dia_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_id))
        else $error("stalled result changed");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_FOUND || status == ST_ADDED || status == ST_FULL))
        else $error("bad status");
    a_wv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (word_valid == (status == ST_ADDED)))
        else $error("word_valid mismatch");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> result_id == 32'd0 && last_word)
        else $error("full result malformed");
endmodule

bind dedup_id_allocator dia_checker u_dia_checker (
    .clk, .rst_n, .out_valid, .out_stall, .result_id, .status, .word_valid,
    .last_word);

// File: tb/testbench.sv
// testbench: self-checking bench for dedup_id_allocator (type/constant dedup tables).
// Depends on dia_pkg and the dedup_id_allocator RTL; needs no other file.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dia_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic        func;
        logic [15:0] opcode;
        logic [2:0]  cnt;
        logic [31:0] opd [7];
        logic        wide;
        logic        boolean_flag;
    } request_t;

    typedef struct {
        logic [31:0] id;
        status_t     st;
        logic [31:0] wrd;
        logic        wv;
        logic        last;
    } result_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic func = 0;
    logic [15:0] opcode = 0;
    logic [2:0] num_operands = 0;
    logic [31:0] operand_a = 0, operand_b = 0, operand_c = 0, operand_d = 0;
    logic [31:0] operand_e = 0, operand_f = 0, operand_g = 0;
    logic is_wide = 0, is_boolean = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [31:0] result_id, word;
    logic [1:0] status;
    logic word_valid, last_word;

    dedup_id_allocator uut (.*);

    always #10 clk = ~clk;

    // Predictor state: the two key tables and the shared id counter.
    logic [31:0] next_id;
    logic [15:0] tk_op [TypeEntries];
    logic [31:0] tk_opd [TypeEntries][7];
    logic [31:0] tk_id [TypeEntries];
    int          t_fill;
    logic [15:0] ck_op [ConstEntries];
    logic [31:0] ck_tid [ConstEntries];
    logic [63:0] ck_val [ConstEntries];
    logic        ck_wide [ConstEntries];
    logic [31:0] ck_id [ConstEntries];
    int          c_fill;

    request_t pending_requests [$];
    result_t  expected_results [$];
    int mismatches = 0;
    int cycles = 0;
    bit calm = 0;      // no idling on either side while set
    bit hold_off = 0;  // sender pauses

    function automatic void push_one(logic [31:0] id, status_t st, logic [31:0] w,
                                     logic wv, logic last);
        result_t r;
        r.id = id; r.st = st; r.wrd = w; r.wv = wv; r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic void push_words(logic [31:0] id, logic [31:0] w [9], int n);
        for (int k = 0; k < n; k++)
            push_one(id, ST_ADDED, w[k], 1'b1, k == n - 1);
    endfunction

    // Look up or insert one request, queueing the results it should produce.
    function automatic void predict_lookup(request_t q);
        logic [31:0] slot [7];
        logic [31:0] w [9];
        logic [31:0] id;
        logic [15:0] op;
        logic [63:0] bits, val;
        bit same;
        for (int k = 0; k < 9; k++) w[k] = 0;
        if (!q.func) begin
            for (int j = 0; j < 7; j++) slot[j] = (j < q.cnt) ? q.opd[j] : 32'd0;
            for (int i = 0; i < t_fill; i++) begin
                same = tk_op[i] == q.opcode;
                for (int j = 0; j < 7; j++) if (tk_opd[i][j] != slot[j]) same = 0;
                if (same) begin
                    push_one(tk_id[i], ST_FOUND, 0, 0, 1);
                    return;
                end
            end
            if (t_fill >= TypeEntries) begin
                push_one(0, ST_FULL, 0, 0, 1);
                return;
            end
            id = next_id; next_id++;
            tk_op[t_fill] = q.opcode;
            for (int j = 0; j < 7; j++) tk_opd[t_fill][j] = slot[j];
            tk_id[t_fill] = id;
            t_fill++;
            w[0] = ((32'(q.cnt) + 2) << WordShift) | q.opcode;
            w[1] = id;
            for (int j = 0; j < q.cnt; j++) w[2 + j] = slot[j];
            push_words(id, w, q.cnt + 2);
        end else begin
            bits = {q.opd[2], q.opd[1]};
            val = q.wide ? bits : {32'd0, q.opd[1]};
            op = q.boolean_flag ? ((bits != 0) ? OP_CONST_TRUE : OP_CONST_FALSE) : OP_CONST;
            for (int i = 0; i < c_fill; i++)
                if (ck_op[i] == op && ck_tid[i] == q.opd[0] && ck_val[i] == val
                    && ck_wide[i] == q.wide) begin
                    push_one(ck_id[i], ST_FOUND, 0, 0, 1);
                    return;
                end
            if (c_fill >= ConstEntries) begin
                push_one(0, ST_FULL, 0, 0, 1);
                return;
            end
            id = next_id; next_id++;
            ck_op[c_fill] = op; ck_tid[c_fill] = q.opd[0]; ck_val[c_fill] = val;
            ck_wide[c_fill] = q.wide; ck_id[c_fill] = id;
            c_fill++;
            w[1] = q.opd[0]; w[2] = id; w[3] = q.opd[1]; w[4] = q.opd[2];
            if (q.boolean_flag) begin
                w[0] = (32'd3 << WordShift) | op;
                push_words(id, w, 3);
            end else if (q.wide) begin
                w[0] = (32'd5 << WordShift) | op;
                push_words(id, w, 5);
            end else begin
                w[0] = (32'd4 << WordShift) | op;
                push_words(id, w, 4);
            end
        end
    endfunction

    // Driver: keeps the current request stable while stalled.
    always @(posedge clk) begin
        request_t q;
        bit accepted;
        accepted = in_valid && !in_stall;
        if (accepted) predict_lookup('{func, opcode, num_operands,
            '{operand_a, operand_b, operand_c, operand_d, operand_e, operand_f,
              operand_g}, is_wide, is_boolean});
        if (rst_n && (!in_valid || accepted)) begin
            if (pending_requests.size() > 0 && !hold_off
                && (calm || $urandom_range(99) >= 32)) begin
                q = pending_requests.pop_front();
                in_valid <= 1;
                func <= q.func; opcode <= q.opcode; num_operands <= q.cnt;
                operand_a <= q.opd[0]; operand_b <= q.opd[1]; operand_c <= q.opd[2];
                operand_d <= q.opd[3]; operand_e <= q.opd[4]; operand_f <= q.opd[5];
                operand_g <= q.opd[6];
                is_wide <= q.wide; is_boolean <= q.boolean_flag;
            end else
                in_valid <= 0;
        end
    end

    // Monitor: compares every accepted result with the oldest expectation.
    always @(posedge clk) begin
        result_t e;
        cycles++;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result id=%h status=%0d word=%h wv=%b last=%b",
                             result_id, status, word, word_valid, last_word);
            end else begin
                e = expected_results.pop_front();
                if (result_id !== e.id || status !== e.st || word !== e.wrd
                    || word_valid !== e.wv || last_word !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp id=%h st=%0d w=%h wv=%b l=%b, got id=%h st=%0d w=%h wv=%b l=%b",
                                 e.id, e.st, e.wrd, e.wv, e.last, result_id, status,
                                 word, word_valid, last_word);
                end
            end
        end
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic request_t mk_type(logic [15:0] op, logic [2:0] n);
        request_t q;
        q.func = 0; q.opcode = op; q.cnt = n;
        for (int j = 0; j < 7; j++) q.opd[j] = $urandom_range(3);
        q.wide = 1'($urandom); q.boolean_flag = 1'($urandom);
        return q;
    endfunction

    function automatic request_t mk_const(logic [31:0] tid, logic [31:0] lo,
                                          logic [31:0] hi, logic w, logic b);
        request_t q;
        q.func = 1; q.opcode = 16'($urandom); q.cnt = 3'($urandom);
        for (int j = 0; j < 7; j++) q.opd[j] = $urandom;
        q.opd[0] = tid; q.opd[1] = lo; q.opd[2] = hi;
        q.wide = w; q.boolean_flag = b;
        return q;
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(3))
            0: return $urandom_range(3);
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_empty();
        while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        request_t q;
        next_id = 1; t_fill = 0; c_fill = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;

        // Directed: field extremes, slot masking, all constant flavors.
        q = mk_type(16'hFFFF, 3'd7);
        for (int j = 0; j < 7; j++) q.opd[j] = 32'hFFFF_FFFF;
        pending_requests.push_back(q);
        pending_requests.push_back(q);                       // hit
        q = mk_type(16'h0000, 3'd0);
        pending_requests.push_back(q);
        q.cnt = 3'd2; q.opd[0] = 0; q.opd[1] = 0;
        pending_requests.push_back(q);                       // zero operands == unused slots
        q = mk_type(16'd5, 3'd2); q.opd[0] = 9; q.opd[1] = 8;
        pending_requests.push_back(q);
        q.opd[2] = 32'hDEAD; q.opd[6] = 32'hBEEF;
        pending_requests.push_back(q);                       // junk above count ignored
        pending_requests.push_back(mk_const(1, 0, 0, 0, 0));
        pending_requests.push_back(mk_const(1, 0, 32'hFFFF_FFFF, 0, 0)); // hi ignored, hit
        pending_requests.push_back(mk_const(1, 0, 32'hFFFF_FFFF, 1, 0)); // wide miss
        pending_requests.push_back(mk_const(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF, 1, 0));
        pending_requests.push_back(mk_const(2, 0, 0, 0, 1));              // false
        pending_requests.push_back(mk_const(2, 0, 1, 0, 1));              // true from hi
        pending_requests.push_back(mk_const(2, 5, 0, 0, 1));              // true, new key
        pending_requests.push_back(mk_const(2, 0, 1, 1, 1));              // bool + wide
        pending_requests.push_back(mk_const(2, 0, 1, 1, 1));              // hit
        pending_requests.push_back(mk_type(16'd41, 3'd1));
        calm = 1;
        wait_empty();
        calm = 0;

        // Random: mostly repeat-prone small keys so hits are common, until tables fill.
        for (int n = 0; n < 270; n++) begin
            if ($urandom_range(1)) begin
                q = mk_type(16'($urandom_range(7)), 3'($urandom_range(7)));
                if ($urandom_range(5) == 0) begin
                    q.opcode = 16'($urandom);
                    for (int j = 0; j < 7; j++) q.opd[j] = rnd_word();
                end
            end else
                q = mk_const($urandom_range(3), $urandom_range(3), $urandom_range(1),
                             1'($urandom), 1'($urandom));
            if ($urandom_range(5) == 0) q = mk_const(rnd_word(), rnd_word(), rnd_word(),
                                                     1'($urandom), 1'($urandom));
            pending_requests.push_back(q);
            if (n == 90) begin
                wait_empty();
                hold_off = 1;
                repeat (30) @(posedge clk);
                hold_off = 0;
                calm = 1;
            end
            if (n == 150) begin
                wait_empty();
                calm = 0;
            end
        end
        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/dia_pkg.sv
hw/rtl/dia_ram.sv
hw/rtl/dia_front.sv
hw/rtl/dia_back.sv
hw/rtl/dedup_id_allocator.sv
hw/rtl/dia_checker.sv
tb/testbench.sv
